FILE: hdl/bfcs_pkg.sv
// Shared package for the bilinear fill/crop scaler.
// Holds widths, codes, controller command/status structs and channel helpers.
// No dependencies.
`default_nettype none

package bfcs_pkg;

    localparam int PIX_W      = 24;
    localparam int COORD_W    = 12;
    localparam int SRC_W      = 9;
    localparam int DST_W      = 13;
    localparam int CROSS_W    = SRC_W + DST_W;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;
    localparam int DVD_W      = 40;
    localparam int DVS_W      = 13;
    localparam int OFS_W      = 21;
    localparam int MULA_W     = OFS_W + 1;
    localparam int PROD_W     = MULA_W + DVS_W;
    localparam int CRD_W      = SRC_W + 8;
    localparam int WGT_W      = 17;
    localparam int SUM_W      = 25;
    localparam int DST_MAX    = 4096;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int MAX_HEIGHT_DEF = 256;

    localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_WIDTH  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_HEIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PIX_FMT    = 3'd4;

    localparam logic OP_STORE   = 1'b0;
    localparam logic OP_REQUEST = 1'b1;

    localparam logic FMT_RGB888 = 1'b0;
    localparam logic FMT_RGB565 = 1'b1;

    localparam logic [1:0] CH_RED   = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_BLUE  = 2'd2;

    typedef struct packed {
        logic       accept;
        logic       prep;
        logic       sel;
        logic       chs;
        logic       mul;
        logic       div_start;
        logic       div_take;
        logic       ofs;
        logic       crd;
        logic       rd_issue;
        logic       rd_take;
        logic       wgt;
        logic       chan;
        logic       cpy_issue;
        logic       cpy_take;
        logic       out_load;
        logic [1:0] cnt;
    } cmd_t;

    typedef struct packed {
        logic eq_sizes;
        logic div_busy;
        logic out_busy;
    } stat_t;

    function automatic logic [4:0] chan_shift(input logic fmt, input logic [1:0] ch);
        logic [4:0] s;
        case (ch)
            CH_RED:   s = (fmt == FMT_RGB565) ? 5'd11 : 5'd16;
            CH_GREEN: s = (fmt == FMT_RGB565) ? 5'd5 : 5'd8;
            default:  s = 5'd0;
        endcase
        return s;
    endfunction

    function automatic logic [7:0] chan_max(input logic fmt, input logic [1:0] ch);
        logic [7:0] m;
        if (fmt == FMT_RGB888)
            m = 8'hFF;
        else if (ch == CH_GREEN)
            m = 8'h3F;
        else
            m = 8'h1F;
        return m;
    endfunction

    function automatic logic [7:0] chan_get(input logic [PIX_W-1:0] pix, input logic fmt,
                                            input logic [1:0] ch);
        logic [PIX_W-1:0] s;
        s = pix >> chan_shift(fmt, ch);
        return s[7:0] & chan_max(fmt, ch);
    endfunction

endpackage

`default_nettype wire

FILE: hdl/bilinear_fill_crop_scaler.sv
// Top level of the bilinear fill/crop scaler: controller, datapath, divider, frame store.
// Depends on bfcs_pkg, bfcs_ctrl, bfcs_dpath, bfcs_div, bfcs_store.
//
//   channel | handshake              | payload
//   --------+------------------------+------------------------------------
//   in      | in_valid / in_stall    | op, col, row, pixel_in
//   out     | out_valid / out_stall  | pixel_out
//   cfg     | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// An equal-size request is a direct copy from the frame store.
// A scaled request runs four multiply/divide passes (40 quotient bits each), then four
// single-port frame store reads.
// Reset initialises control and configuration state; frame store contents are undefined.
// Output stall holds the result register; the next transaction is taken meanwhile.
`default_nettype none

module bilinear_fill_crop_scaler
    import bfcs_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  op,
    input  wire logic [COORD_W-1:0]    col,
    input  wire logic [COORD_W-1:0]    row,
    input  wire logic [PIX_W-1:0]      pixel_in,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic [PIX_W-1:0]           pixel_out,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);

    cmd_t             cmd;
    stat_t            stat;
    logic             div_start, div_busy;
    logic [DVD_W-1:0] div_dividend, div_quotient;
    logic [DVS_W-1:0] div_divisor;
    logic             mem_we, mem_re;
    logic [AW-1:0]    mem_addr;
    logic [PIX_W-1:0] mem_wdata, mem_rdata;

    assign cfg_ready = 1'b1;

    bfcs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .op       (op),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    bfcs_dpath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .AW         (AW)
    ) u_dpath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .cfg_wr       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .op           (op),
        .col          (col),
        .row          (row),
        .pixel_in     (pixel_in),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .pixel_out    (pixel_out),
        .div_start    (div_start),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_busy     (div_busy),
        .div_quotient (div_quotient),
        .mem_we       (mem_we),
        .mem_re       (mem_re),
        .mem_addr     (mem_addr),
        .mem_wdata    (mem_wdata),
        .mem_rdata    (mem_rdata)
    );

    bfcs_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quotient)
    );

    bfcs_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .clk   (clk),
        .we    (mem_we),
        .re    (mem_re),
        .addr  (mem_addr),
        .wdata (mem_wdata),
        .rdata (mem_rdata)
    );

`ifndef NO_ASSERTIONS
    a_store_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && op == OP_STORE && !out_valid) |=> !out_valid)
        else $error("store transaction produced a result");

    a_request_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && op == OP_REQUEST) |=> in_stall)
        else $error("input taken again straight after a request");

    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared without a request in progress");
`endif

endmodule

`default_nettype wire

FILE: hdl/bfcs_div.sv
// Restoring divider, one quotient bit per cycle.
// Depends on bfcs_pkg.
`default_nettype none

module bfcs_div
    import bfcs_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    input  wire logic [DVD_W-1:0] dividend,
    input  wire logic [DVS_W-1:0] divisor,
    output logic                  busy,
    output logic [DVD_W-1:0]      quotient
);

    localparam int CNT_W = $clog2(DVD_W + 1);

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] rem_reg, rem_next;
    logic [DVS_W-1:0] dvs_reg;
    logic [DVS_W:0]   trial;
    logic             ge;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DVD_W-1]};
        ge       = trial >= {1'b0, dvs_reg};
        rem_next = ge ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
        quo_next = {quo_reg[DVD_W-2:0], ge};
        cnt_next = cnt_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else if (start)
            cnt_reg <= CNT_W'(DVD_W);
        else if (busy)
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = cnt_reg != '0;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

FILE: hdl/bfcs_store.sv
// Single-port frame store with registered read data.
// Depends on bfcs_pkg.
`default_nettype none

module bfcs_store
    import bfcs_pkg::*;
#(
    parameter int DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF,
    parameter int AW    = $clog2(DEPTH)
)
(
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic             re,
    input  wire logic [AW-1:0]    addr,
    input  wire logic [PIX_W-1:0] wdata,
    output logic [PIX_W-1:0]      rdata
);

    logic [PIX_W-1:0] mem [DEPTH];
    logic [PIX_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[addr] <= wdata;
        if (re)
            rdata_reg <= mem[addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/bfcs_dpath.sv
// Datapath: configuration registers, crop/coordinate arithmetic, interpolation, output register.
// Depends on bfcs_pkg; driven by bfcs_ctrl, uses bfcs_div and bfcs_store through the top level.
`default_nettype none

module bfcs_dpath
    import bfcs_pkg::*;
#(
    parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
    parameter int AW         = $clog2(MAX_WIDTH * MAX_HEIGHT)
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire cmd_t                  cmd,
    output stat_t                      stat,
    input  wire logic                  cfg_wr,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  op,
    input  wire logic [COORD_W-1:0]    col,
    input  wire logic [COORD_W-1:0]    row,
    input  wire logic [PIX_W-1:0]      pixel_in,
    input  wire logic                  out_stall,
    output logic                       out_valid,
    output logic [PIX_W-1:0]           pixel_out,
    output logic                       div_start,
    output logic [DVD_W-1:0]           div_dividend,
    output logic [DVS_W-1:0]           div_divisor,
    input  wire logic                  div_busy,
    input  wire logic [DVD_W-1:0]      div_quotient,
    output logic                       mem_we,
    output logic                       mem_re,
    output logic [AW-1:0]              mem_addr,
    output logic [PIX_W-1:0]           mem_wdata,
    input  wire logic [PIX_W-1:0]      mem_rdata
);

    function automatic logic [AW-1:0] addr_of(input logic [COORD_W-1:0] x,
                                             input logic [COORD_W-1:0] y);
        return AW'(32'(y) * MAX_WIDTH + 32'(x));
    endfunction

    logic [SRC_W-1:0]   src_width_reg, src_height_reg;
    logic [DST_W-1:0]   dst_width_reg, dst_height_reg;
    logic               fmt_reg;
    logic               out_valid_reg, out_valid_next;

    logic [COORD_W-1:0] col_reg, row_reg;
    logic [SRC_W-1:0]   sw_reg, sh_reg, den_reg;
    logic [DST_W-1:0]   dw_reg, dh_reg, num_reg;
    logic [CROSS_W-1:0] xa_reg, xb_reg;
    logic               eq_reg;
    logic [OFS_W-1:0]   scw_reg, sch_reg, ox_reg, oy_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [CRD_W-1:0]   sx_reg, sy_reg;
    logic [SRC_W-1:0]   x0_reg, x1_reg, y0_reg, y1_reg;
    logic [7:0]         fx_reg, fy_reg;
    logic [PIX_W-1:0]   p_reg [4];
    logic [WGT_W-1:0]   w00_reg, w10_reg, w01_reg, w11_reg;
    logic [PIX_W-1:0]   res_reg, res_next;
    logic [PIX_W-1:0]   pix_out_reg;

    logic [SRC_W-1:0]   sw_next, sh_next;
    logic [DST_W-1:0]   dw_next, dh_next;
    logic [MULA_W-1:0]  mul_a;
    logic [DVS_W-1:0]   mul_b;
    logic [CRD_W-1:0]   lim_x, lim_y;
    logic [SRC_W-1:0]   x0_next, y0_next, x1_next, y1_next;
    logic [SRC_W-1:0]   cx, cy;
    logic [AW-1:0]      rd_addr;
    logic [8:0]         wx0, wy0;
    logic [7:0]         ca, cb, cd, ce, cmax;
    logic [SUM_W-1:0]   sum, rounded;
    logic [8:0]         v;
    logic [7:0]         vs;
    logic               store_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_width_reg  <= SRC_W'(256);
            src_height_reg <= SRC_W'(256);
            dst_width_reg  <= DST_W'(256);
            dst_height_reg <= DST_W'(256);
            fmt_reg        <= FMT_RGB888;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                CFG_SRC_WIDTH:  src_width_reg  <= cfg_data[SRC_W-1:0];
                CFG_SRC_HEIGHT: src_height_reg <= cfg_data[SRC_W-1:0];
                CFG_DST_WIDTH:  dst_width_reg  <= cfg_data[DST_W-1:0];
                CFG_DST_HEIGHT: dst_height_reg <= cfg_data[DST_W-1:0];
                CFG_PIX_FMT:    fmt_reg        <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        if (src_width_reg == '0)
            sw_next = SRC_W'(1);
        else if (DST_W'(src_width_reg) > DST_W'(MAX_WIDTH))
            sw_next = SRC_W'(MAX_WIDTH);
        else
            sw_next = src_width_reg;
        if (src_height_reg == '0)
            sh_next = SRC_W'(1);
        else if (DST_W'(src_height_reg) > DST_W'(MAX_HEIGHT))
            sh_next = SRC_W'(MAX_HEIGHT);
        else
            sh_next = src_height_reg;
        if (dst_width_reg == '0)
            dw_next = DST_W'(1);
        else if (dst_width_reg > DST_W'(DST_MAX))
            dw_next = DST_W'(DST_MAX);
        else
            dw_next = dst_width_reg;
        if (dst_height_reg == '0)
            dh_next = DST_W'(1);
        else if (dst_height_reg > DST_W'(DST_MAX))
            dh_next = DST_W'(DST_MAX);
        else
            dh_next = dst_height_reg;
    end

    always_comb
    begin
        case (cmd.cnt)
            2'd0:    mul_a = MULA_W'(sw_reg);
            2'd1:    mul_a = MULA_W'(sh_reg);
            2'd2:    mul_a = MULA_W'(col_reg) + MULA_W'(ox_reg);
            default: mul_a = MULA_W'(row_reg) + MULA_W'(oy_reg);
        endcase
        mul_b        = cmd.cnt[1] ? DVS_W'(den_reg) : num_reg;
        div_dividend = cmd.cnt[1] ? DVD_W'({prod_reg, 8'h00}) : DVD_W'(prod_reg);
        div_divisor  = cmd.cnt[1] ? num_reg : DVS_W'(den_reg);
        div_start    = cmd.div_start;
    end

    always_comb
    begin
        lim_x   = (sw_reg >= SRC_W'(2)) ? CRD_W'({sw_reg - SRC_W'(1), 8'h00}) - CRD_W'(1) : '0;
        lim_y   = (sh_reg >= SRC_W'(2)) ? CRD_W'({sh_reg - SRC_W'(1), 8'h00}) - CRD_W'(1) : '0;
        x0_next = sx_reg[CRD_W-1:8];
        y0_next = sy_reg[CRD_W-1:8];
        x1_next = ({1'b0, x0_next} + 10'd1 < {1'b0, sw_reg}) ? x0_next + SRC_W'(1)
                                                             : sw_reg - SRC_W'(1);
        y1_next = ({1'b0, y0_next} + 10'd1 < {1'b0, sh_reg}) ? y0_next + SRC_W'(1)
                                                             : sh_reg - SRC_W'(1);
        cx      = (col_reg < COORD_W'(sw_reg)) ? col_reg[SRC_W-1:0] : sw_reg - SRC_W'(1);
        cy      = (row_reg < COORD_W'(sh_reg)) ? row_reg[SRC_W-1:0] : sh_reg - SRC_W'(1);
    end

    always_comb
    begin
        case (cmd.cnt)
            2'd0:    rd_addr = addr_of(COORD_W'(x0_reg), COORD_W'(y0_reg));
            2'd1:    rd_addr = addr_of(COORD_W'(x1_reg), COORD_W'(y0_reg));
            2'd2:    rd_addr = addr_of(COORD_W'(x0_reg), COORD_W'(y1_reg));
            default: rd_addr = addr_of(COORD_W'(x1_reg), COORD_W'(y1_reg));
        endcase
        store_hit = (32'(col) < MAX_WIDTH) && (32'(row) < MAX_HEIGHT);
        mem_we    = cmd.accept && (op == OP_STORE) && store_hit;
        mem_re    = cmd.rd_issue || cmd.cpy_issue;
        mem_wdata = pixel_in;
        if (cmd.accept)
            mem_addr = addr_of(col, row);
        else if (cmd.cpy_issue)
            mem_addr = addr_of(COORD_W'(cx), COORD_W'(cy));
        else
            mem_addr = rd_addr;
    end

    always_comb
    begin
        wx0      = 9'd256 - 9'(fx_reg);
        wy0      = 9'd256 - 9'(fy_reg);
        ca       = chan_get(p_reg[0], fmt_reg, cmd.cnt);
        cb       = chan_get(p_reg[1], fmt_reg, cmd.cnt);
        cd       = chan_get(p_reg[2], fmt_reg, cmd.cnt);
        ce       = chan_get(p_reg[3], fmt_reg, cmd.cnt);
        cmax     = chan_max(fmt_reg, cmd.cnt);
        sum      = SUM_W'(w00_reg) * SUM_W'(ca) + SUM_W'(w10_reg) * SUM_W'(cb)
                 + SUM_W'(w01_reg) * SUM_W'(cd) + SUM_W'(w11_reg) * SUM_W'(ce);
        rounded  = sum + SUM_W'(32768);
        v        = rounded[SUM_W-1:16];
        vs       = (v > {1'b0, cmax}) ? cmax : v[7:0];
        res_next = res_reg | (PIX_W'(vs) << chan_shift(fmt_reg, cmd.cnt));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            col_reg <= col;
            row_reg <= row;
        end
        if (cmd.prep)
        begin
            sw_reg <= sw_next;
            sh_reg <= sh_next;
            dw_reg <= dw_next;
            dh_reg <= dh_next;
        end
        if (cmd.sel)
        begin
            xa_reg <= CROSS_W'(dw_reg) * CROSS_W'(sh_reg);
            xb_reg <= CROSS_W'(dh_reg) * CROSS_W'(sw_reg);
            eq_reg <= (DST_W'(sw_reg) == dw_reg) && (DST_W'(sh_reg) == dh_reg);
        end
        if (cmd.chs)
        begin
            num_reg <= (xa_reg > xb_reg) ? dw_reg : dh_reg;
            den_reg <= (xa_reg > xb_reg) ? sw_reg : sh_reg;
        end
        if (cmd.mul)
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (cmd.div_take)
        begin
            case (cmd.cnt)
                2'd0: scw_reg <= div_quotient[OFS_W-1:0];
                2'd1: sch_reg <= div_quotient[OFS_W-1:0];
                2'd2: sx_reg  <= (div_quotient > DVD_W'(lim_x)) ? lim_x
                                                                : div_quotient[CRD_W-1:0];
                default: sy_reg <= (div_quotient > DVD_W'(lim_y)) ? lim_y
                                                                  : div_quotient[CRD_W-1:0];
            endcase
        end
        if (cmd.ofs)
        begin
            ox_reg <= (scw_reg > OFS_W'(dw_reg)) ? (scw_reg - OFS_W'(dw_reg)) >> 1 : '0;
            oy_reg <= (sch_reg > OFS_W'(dh_reg)) ? (sch_reg - OFS_W'(dh_reg)) >> 1 : '0;
        end
        if (cmd.crd)
        begin
            x0_reg <= x0_next;
            y0_reg <= y0_next;
            x1_reg <= x1_next;
            y1_reg <= y1_next;
            fx_reg <= sx_reg[7:0];
            fy_reg <= sy_reg[7:0];
        end
        if (cmd.rd_take)
            p_reg[cmd.cnt] <= mem_rdata;
        if (cmd.wgt)
        begin
            w00_reg <= WGT_W'(wx0) * WGT_W'(wy0);
            w10_reg <= WGT_W'(fx_reg) * WGT_W'(wy0);
            w01_reg <= WGT_W'(wx0) * WGT_W'(fy_reg);
            w11_reg <= WGT_W'(fx_reg) * WGT_W'(fy_reg);
            res_reg <= '0;
        end
        else if (cmd.chan)
            res_reg <= res_next;
        else if (cmd.cpy_take)
            res_reg <= (fmt_reg == FMT_RGB565) ? {8'h00, mem_rdata[15:0]} : mem_rdata;
        if (cmd.out_load)
            pix_out_reg <= res_reg;
    end

    always_comb
    begin
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign stat.eq_sizes = eq_reg;
    assign stat.div_busy = div_busy;
    assign stat.out_busy = out_valid_reg && out_stall;
    assign out_valid     = out_valid_reg;
    assign pixel_out     = pix_out_reg;

endmodule

`default_nettype wire

FILE: hdl/bfcs_ctrl.sv
// Controller state machine: sequences crop, coordinate, fetch and blend steps, or a direct copy when sizes match.
// Depends on bfcs_pkg; drives bfcs_dpath through cmd_t.
`default_nettype none

module bfcs_ctrl
    import bfcs_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    input  wire logic  op,
    output logic       in_stall,
    input  wire stat_t stat,
    output cmd_t       cmd
);

    typedef enum logic [15:0] {
        ST_IDLE = 16'b0000_0000_0000_0001,
        ST_PREP = 16'b0000_0000_0000_0010,
        ST_SEL  = 16'b0000_0000_0000_0100,
        ST_CHS  = 16'b0000_0000_0000_1000,
        ST_MUL  = 16'b0000_0000_0001_0000,
        ST_DST  = 16'b0000_0000_0010_0000,
        ST_DIV  = 16'b0000_0000_0100_0000,
        ST_OFS  = 16'b0000_0000_1000_0000,
        ST_CRD  = 16'b0000_0001_0000_0000,
        ST_RD   = 16'b0000_0010_0000_0000,
        ST_RDW  = 16'b0000_0100_0000_0000,
        ST_WGT  = 16'b0000_1000_0000_0000,
        ST_CHAN = 16'b0001_0000_0000_0000,
        ST_CPY  = 16'b0010_0000_0000_0000,
        ST_CPYW = 16'b0100_0000_0000_0000,
        ST_OUT  = 16'b1000_0000_0000_0000
    } state_t;

    state_t     state_reg, state_next;
    logic [1:0] cnt_reg, cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        cmd.cnt    = cnt_reg;
        in_stall   = state_reg != ST_IDLE;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (op == OP_REQUEST)
                        state_next = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = ST_SEL;
            end
            ST_SEL:
            begin
                cmd.sel    = 1'b1;
                state_next = ST_CHS;
            end
            ST_CHS:
            begin
                cmd.chs    = 1'b1;
                cnt_next   = 2'd0;
                state_next = stat.eq_sizes ? ST_CPY : ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_DST;
            end
            ST_DST:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (!stat.div_busy)
                begin
                    cmd.div_take = 1'b1;
                    cnt_next     = cnt_reg + 2'd1;
                    if (cnt_reg == 2'd1)
                        state_next = ST_OFS;
                    else if (cnt_reg == 2'd3)
                        state_next = ST_CRD;
                    else
                        state_next = ST_MUL;
                end
            end
            ST_OFS:
            begin
                cmd.ofs    = 1'b1;
                state_next = ST_MUL;
            end
            ST_CRD:
            begin
                cmd.crd    = 1'b1;
                cnt_next   = 2'd0;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = ST_RDW;
            end
            ST_RDW:
            begin
                cmd.rd_take = 1'b1;
                cnt_next    = cnt_reg + 2'd1;
                state_next  = (cnt_reg == 2'd3) ? ST_WGT : ST_RD;
            end
            ST_WGT:
            begin
                cmd.wgt    = 1'b1;
                cnt_next   = CH_RED;
                state_next = ST_CHAN;
            end
            ST_CHAN:
            begin
                cmd.chan   = 1'b1;
                cnt_next   = cnt_reg + 2'd1;
                state_next = (cnt_reg == CH_BLUE) ? ST_OUT : ST_CHAN;
            end
            ST_CPY:
            begin
                cmd.cpy_issue = 1'b1;
                state_next    = ST_CPYW;
            end
            ST_CPYW:
            begin
                cmd.cpy_take = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

`default_nettype wire

FILE: verif/testbench.sv
// Self-checking testbench for bilinear_fill_crop_scaler: directed table, then random phases.
// Carries its own scaler predictor and frame store copy; checks each result in order.
// Depends on bfcs_pkg and the scaler RTL.
`default_nettype none

module testbench;
    import bfcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_DEPTH = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_ITEMS = 500;
    localparam int HOLD_CYCLES = 1500;
    localparam int DRAIN_CYCLES = 250;

    typedef enum logic [1:0] {ROW_STORE, ROW_REQ, ROW_CFG} row_kind_t;
    typedef enum logic [1:0] {IDLE_SENDER_LIGHT, IDLE_SENDER_HEAVY, IDLE_NONE} idle_mode_t;

    typedef struct {
        row_kind_t         kind;
        int unsigned       x;
        int unsigned       y;
        logic [PIX_W-1:0]  data;
        logic [CFG_IDX_W-1:0] idx;
        bit                typed;
        logic [PIX_W-1:0]  want;
    } dir_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    logic                  op = OP_STORE;
    logic [COORD_W-1:0]    col = '0;
    logic [COORD_W-1:0]    row = '0;
    logic [PIX_W-1:0]      pixel_in = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    logic [PIX_W-1:0]      pixel_out;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic [PIX_W-1:0] frame_copy [FRAME_DEPTH];
    logic [SRC_W-1:0] m_src_w;
    logic [SRC_W-1:0] m_src_h;
    logic [DST_W-1:0] m_dst_w;
    logic [DST_W-1:0] m_dst_h;
    logic             m_fmt;

    logic [PIX_W-1:0] pending_pixels [$];
    dir_row_t         directed [$];
    idle_mode_t       idle_mode = IDLE_SENDER_LIGHT;
    bit               hold_go = 1'b0;
    int unsigned      errors = 0;
    int unsigned      checked = 0;
    int unsigned      stores_sent = 0;
    int unsigned      random_items = 0;
    int unsigned      phases = 0;
    int unsigned      cycles = 0;

    bilinear_fill_crop_scaler dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .op        (op),
        .col       (col),
        .row       (row),
        .pixel_in  (pixel_in),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .pixel_out (pixel_out),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILED: results differ");
            $finish;
        end
    end

    function automatic longint unsigned clamp_to(input longint unsigned v,
                                                 input longint unsigned lo,
                                                 input longint unsigned hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint unsigned src_coord(input longint unsigned d,
                                                  input longint unsigned den,
                                                  input longint unsigned num,
                                                  input longint unsigned size);
        longint unsigned s;
        longint unsigned lim;
        s = (d * den * 256) / num;
        lim = size >= 2 ? (size - 1) * 256 - 1 : 0;
        return s > lim ? lim : s;
    endfunction

    function automatic logic [PIX_W-1:0] frame_at(input longint unsigned x,
                                                  input longint unsigned y);
        return frame_copy[(y * MAX_WIDTH_DEF + x) % FRAME_DEPTH];
    endfunction

    function automatic logic [PIX_W-1:0] scale_pixel(input longint unsigned c,
                                                     input longint unsigned r);
        longint unsigned sw, sh, dw, dh, num, den, scw, sch, ox, oy, sx, sy;
        longint unsigned x0, y0, x1, y1, fx, fy, a, b, d, e, sum, v, mk;
        logic [PIX_W-1:0] p00, p10, p01, p11, p;
        logic [PIX_W-1:0] res;
        int shf;
        sw = clamp_to(m_src_w, 1, MAX_WIDTH_DEF);
        sh = clamp_to(m_src_h, 1, MAX_HEIGHT_DEF);
        dw = clamp_to(m_dst_w, 1, DST_MAX);
        dh = clamp_to(m_dst_h, 1, DST_MAX);
        if (sw == dw && sh == dh)
        begin
            p = frame_at(c < sw ? c : sw - 1, r < sh ? r : sh - 1);
            return (m_fmt == FMT_RGB565) ? {8'h00, p[15:0]} : p;
        end
        if (dw * sh > dh * sw)
        begin
            num = dw;
            den = sw;
        end
        else
        begin
            num = dh;
            den = sh;
        end
        scw = sw * num / den;
        sch = sh * num / den;
        ox = scw > dw ? (scw - dw) / 2 : 0;
        oy = sch > dh ? (sch - dh) / 2 : 0;
        sx = src_coord(c + ox, den, num, sw);
        sy = src_coord(r + oy, den, num, sh);
        x0 = sx >> 8;
        fx = sx & 255;
        y0 = sy >> 8;
        fy = sy & 255;
        x1 = x0 + 1 < sw ? x0 + 1 : sw - 1;
        y1 = y0 + 1 < sh ? y0 + 1 : sh - 1;
        p00 = frame_at(x0, y0);
        p10 = frame_at(x1, y0);
        p01 = frame_at(x0, y1);
        p11 = frame_at(x1, y1);
        res = '0;
        for (int ch = 0; ch < 3; ch++)
        begin
            if (m_fmt == FMT_RGB565)
            begin
                shf = (ch == 0) ? 11 : (ch == 1 ? 5 : 0);
                mk = (ch == 1) ? 63 : 31;
            end
            else
            begin
                shf = (ch == 0) ? 16 : (ch == 1 ? 8 : 0);
                mk = 255;
            end
            a = (p00 >> shf) & mk;
            b = (p10 >> shf) & mk;
            d = (p01 >> shf) & mk;
            e = (p11 >> shf) & mk;
            sum = (256 - fx) * (256 - fy) * a + fx * (256 - fy) * b
                + (256 - fx) * fy * d + fx * fy * e;
            v = (sum + 32768) >> 16;
            if (v > mk)
                v = mk;
            res = res | PIX_W'(v << shf);
        end
        return res;
    endfunction

    task automatic send_item(input logic kind, input int unsigned x, input int unsigned y,
                             input logic [PIX_W-1:0] pix, input bit typed,
                             input logic [PIX_W-1:0] want);
        int unsigned gap_pct;
        gap_pct = (idle_mode == IDLE_SENDER_LIGHT) ? 20 :
                  (idle_mode == IDLE_SENDER_HEAVY) ? 60 : 0;
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        op <= kind;
        col <= COORD_W'(x);
        row <= COORD_W'(y);
        pixel_in <= pix;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        if (kind == OP_STORE)
        begin
            stores_sent++;
            if (x < MAX_WIDTH_DEF && y < MAX_HEIGHT_DEF)
                frame_copy[y * MAX_WIDTH_DEF + x] = pix;
        end
        else
            pending_pixels.push_back(typed ? want : scale_pixel(x, y));
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_SRC_WIDTH:  m_src_w = SRC_W'(value);
            CFG_SRC_HEIGHT: m_src_h = SRC_W'(value);
            CFG_DST_WIDTH:  m_dst_w = DST_W'(value);
            CFG_DST_HEIGHT: m_dst_h = DST_W'(value);
            CFG_PIX_FMT:    m_fmt = value[0];
            default: ;
        endcase
    endtask

    task automatic random_phase(input bit pressure);
        int unsigned raw_sw, raw_sh, raw_dw, raw_dh, sw, sh, dw, pick, n_req;
        int unsigned x, y;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            raw_sw = $urandom_range(1) ? 256 : 511;
            raw_sh = $urandom_range(1, 2);
        end
        else if (pick < 16)
        begin
            raw_sw = $urandom_range(0, 2);
            raw_sh = $urandom_range(1) ? 256 : 300;
        end
        else
        begin
            raw_sw = $urandom_range(0, 12);
            raw_sh = $urandom_range(0, 12);
        end
        sw = 32'(clamp_to(raw_sw, 1, MAX_WIDTH_DEF));
        sh = 32'(clamp_to(raw_sh, 1, MAX_HEIGHT_DEF));
        pick = $urandom_range(99);
        if (pick < 15)
        begin
            raw_dw = sw;
            raw_dh = sh;
        end
        else if (pick < 25)
        begin
            raw_dw = $urandom_range(1) ? 4096 : 8191;
            raw_dh = $urandom_range(0, 1);
        end
        else if (pick < 35)
        begin
            raw_dw = $urandom_range(0, 1);
            raw_dh = $urandom_range(4096, 8191);
        end
        else
        begin
            raw_dw = $urandom_range(0, 48);
            raw_dh = $urandom_range(0, 48);
        end
        settle();
        write_reg(CFG_SRC_WIDTH, raw_sw);
        write_reg(CFG_SRC_HEIGHT, raw_sh);
        write_reg(CFG_DST_WIDTH, raw_dw);
        write_reg(CFG_DST_HEIGHT, raw_dh);
        write_reg(CFG_PIX_FMT, $urandom_range(1));
        cfg_valid <= 1'b0;
        phases++;
        dw = 32'(clamp_to(m_dst_w, 1, DST_MAX));
        for (int unsigned yy = 0; yy < sh; yy++)
            for (int unsigned xx = 0; xx < sw; xx++)
            begin
                if ($urandom_range(99) < 5)
                begin
                    send_item(OP_STORE, $urandom_range(MAX_WIDTH_DEF, 4095),
                              $urandom_range(4095), PIX_W'($urandom()), 1'b0, '0);
                end
                send_item(OP_STORE, xx, yy, PIX_W'($urandom()), 1'b0, '0);
                random_items++;
            end
        if (pressure)
            hold_go = 1'b1;
        n_req = $urandom_range(10, 30);
        for (int unsigned i = 0; i < n_req; i++)
        begin
            if ($urandom_range(99) < 80)
            begin
                x = $urandom_range(dw > 4096 ? 4095 : dw - 1);
                y = $urandom_range(clamp_to(m_dst_h, 1, DST_MAX) - 1);
            end
            else
            begin
                x = $urandom_range(4095);
                y = $urandom_range(4095);
            end
            send_item(OP_REQUEST, x, y, PIX_W'($urandom()), 1'b0, '0);
            random_items++;
        end
    endtask

    always @(posedge clk)
    begin
        int unsigned stall_pct;
        logic [PIX_W-1:0] want;
        int unsigned hold_left;
        if (out_valid && !out_stall)
        begin
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual %06h", $time, pixel_out);
                errors++;
            end
            else
            begin
                want = pending_pixels.pop_front();
                checked++;
                if (pixel_out !== want)
                begin
                    $display("%0t: pixel_out mismatch, expected %06h, actual %06h",
                             $time, want, pixel_out);
                    errors++;
                end
            end
        end
        if (hold_go)
        begin
            hold_go = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        stall_pct = (idle_mode == IDLE_SENDER_LIGHT) ? 60 :
                    (idle_mode == IDLE_SENDER_HEAVY) ? 20 : 0;
        if (hold_left != 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(99) < stall_pct);
    end

    initial
    begin
        m_src_w = SRC_W'(256);
        m_src_h = SRC_W'(256);
        m_dst_w = DST_W'(256);
        m_dst_h = DST_W'(256);
        m_fmt = FMT_RGB888;
        directed = '{
            '{ROW_STORE, 0, 0, 24'hFFFFFF, '0, 1'b0, '0},
            '{ROW_STORE, 255, 255, 24'h000000, '0, 1'b0, '0},
            '{ROW_STORE, 255, 0, 24'hA5A5A5, '0, 1'b0, '0},
            '{ROW_STORE, 0, 255, 24'h5A5A5A, '0, 1'b0, '0},
            '{ROW_STORE, 256, 0, 24'h123456, '0, 1'b0, '0},
            '{ROW_STORE, 0, 4095, 24'h654321, '0, 1'b0, '0},
            '{ROW_REQ, 0, 0, 24'h000000, '0, 1'b1, 24'hFFFFFF},
            '{ROW_REQ, 255, 255, 24'hFFFFFF, '0, 1'b1, 24'h000000},
            '{ROW_REQ, 4095, 4095, 24'h000000, '0, 1'b1, 24'h000000},
            '{ROW_REQ, 4095, 0, 24'h000000, '0, 1'b1, 24'hA5A5A5},
            '{ROW_REQ, 0, 4095, 24'h000000, '0, 1'b1, 24'h5A5A5A},
            '{ROW_CFG, 0, 0, 24'd1, CFG_PIX_FMT, 1'b0, '0},
            '{ROW_REQ, 0, 0, 24'h000000, '0, 1'b1, 24'h00FFFF},
            '{ROW_CFG, 0, 0, 24'd1, CFG_SRC_WIDTH, 1'b0, '0},
            '{ROW_CFG, 0, 0, 24'd1, CFG_SRC_HEIGHT, 1'b0, '0},
            '{ROW_CFG, 0, 0, 24'd4, CFG_DST_WIDTH, 1'b0, '0},
            '{ROW_CFG, 0, 0, 24'd4, CFG_DST_HEIGHT, 1'b0, '0},
            '{ROW_REQ, 2, 1, 24'h000000, '0, 1'b1, 24'h00FFFF},
            '{ROW_CFG, 0, 0, 24'd0, CFG_PIX_FMT, 1'b0, '0},
            '{ROW_REQ, 3, 3, 24'h000000, '0, 1'b1, 24'hFFFFFF},
            '{ROW_REQ, 4095, 4095, 24'hFFFFFF, '0, 1'b0, '0}
        };
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
            begin
                settle();
                write_reg(directed[i].idx, directed[i].data);
                cfg_valid <= 1'b0;
            end
            else
                send_item(directed[i].kind == ROW_REQ ? OP_REQUEST : OP_STORE,
                          directed[i].x, directed[i].y, directed[i].data,
                          directed[i].typed, directed[i].want);
        end
        while (random_items < RANDOM_ITEMS)
        begin
            if (random_items >= 2 * RANDOM_ITEMS / 3)
                idle_mode = IDLE_NONE;
            else if (random_items >= RANDOM_ITEMS / 3)
                idle_mode = IDLE_SENDER_HEAVY;
            random_phase(phases == 0);
        end
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d configuration phases, %0d stores and %0d checked pixels",
                 phases, stores_sent, checked);
        $display("formats, fill and crop, equal-size copy, clamped registers and one long hold");
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

`default_nettype wire
